>>> rtl/decimal_count_run_length_decoder_assert.svh
// assertion macros for the run-length decoder
`ifndef DECIMAL_COUNT_RUN_LENGTH_DECODER_ASSERT_SVH
`define DECIMAL_COUNT_RUN_LENGTH_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define RLD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rld assertion failed");

// next-cycle implication, disabled while reset is held
`define RLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rld assertion failed");

`endif

>>> rtl/rld_pkg.sv
`timescale 1ns / 1ps
package rld_pkg;

    localparam int MAX_REPEAT = 63;
    localparam int CNT_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int QDEPTH     = 2;
    localparam int QAW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW        = $clog2(QDEPTH + 1);

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              flush;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } t_out;

    // one expansion job: rep_cnt copies of rep_sym, then lit_sym if has_lit
    typedef struct packed {
        logic [BYTE_W-1:0] rep_sym;
        logic [CNT_W-1:0]  rep_cnt;
        logic              has_lit;
        logic [BYTE_W-1:0] lit_sym;
    } t_cmd;

    typedef struct packed {
        logic           full;
        logic           empty;
        logic [QCW-1:0] count;
    } t_qstat;

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

endpackage

>>> rtl/rld_front.sv
`timescale 1ns / 1ps
module rld_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  rld_pkg::t_in   i_in,
    output logic           o_push,
    output rld_pkg::t_cmd  o_cmd
);

    logic [rld_pkg::BYTE_W-1:0] r_held;
    logic [rld_pkg::CNT_W-1:0]  r_pend;
    logic [rld_pkg::BYTE_W-1:0] n_held;
    logic [rld_pkg::CNT_W-1:0]  n_pend;

    logic                       w_digit;
    logic [3:0]                 w_dval;
    logic [rld_pkg::CNT_W+3:0]  w_acc;

    assign w_digit = rld_pkg::is_digit(i_in.in_byte);
    assign w_dval  = 4'(i_in.in_byte - rld_pkg::ASCII_ZERO);
    // pending * 10 + digit as shift-add
    assign w_acc   = {1'b0, r_pend, 3'b000} + {3'b000, r_pend, 1'b0}
                   + {{rld_pkg::CNT_W{1'b0}}, w_dval};

    always_comb begin
        n_held        = r_held;
        n_pend        = r_pend;
        o_push        = 1'b0;
        o_cmd.rep_sym = r_held;
        o_cmd.rep_cnt = r_pend;
        o_cmd.has_lit = 1'b0;
        o_cmd.lit_sym = i_in.in_byte;
        if (i_accept) begin
            if (i_in.flush) begin
                n_pend = '0;
                o_push = (r_pend != '0);
            end else if (w_digit) begin
                if (w_acc > (rld_pkg::CNT_W+4)'(rld_pkg::MAX_REPEAT)) begin
                    n_pend = rld_pkg::CNT_W'(rld_pkg::MAX_REPEAT);
                end else begin
                    n_pend = w_acc[rld_pkg::CNT_W-1:0];
                end
            end else begin
                n_pend        = '0;
                n_held        = i_in.in_byte;
                o_push        = 1'b1;
                o_cmd.has_lit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_pend <= '0;
        end else begin
            r_held <= n_held;
            r_pend <= n_pend;
        end
    end

endmodule

>>> rtl/rld_cmdq.sv
`timescale 1ns / 1ps
module rld_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rld_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output rld_pkg::t_cmd   o_cmd,
    output rld_pkg::t_qstat o_stat
);

    rld_pkg::t_cmd             r_mem [rld_pkg::QDEPTH];
    logic [rld_pkg::QAW-1:0]   r_wr;
    logic [rld_pkg::QAW-1:0]   r_rd;
    logic [rld_pkg::QCW-1:0]   r_cnt;

    logic w_wr;
    logic w_rd;

    assign w_wr = i_push && (r_cnt != rld_pkg::QCW'(rld_pkg::QDEPTH));
    assign w_rd = i_pop && (r_cnt != '0);

    assign o_cmd        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == rld_pkg::QCW'(rld_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

    function automatic logic [rld_pkg::QAW-1:0] nxt_ptr(input logic [rld_pkg::QAW-1:0] p);
        if (p == rld_pkg::QAW'(rld_pkg::QDEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= nxt_ptr(r_wr);
            end
            if (w_rd) begin
                r_rd <= nxt_ptr(r_rd);
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/rld_back.sv
`timescale 1ns / 1ps
module rld_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rld_pkg::t_cmd   i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output rld_pkg::t_out   o_out
);

    logic [rld_pkg::BYTE_W-1:0] r_rep_sym;
    logic [rld_pkg::BYTE_W-1:0] r_lit_sym;
    logic [rld_pkg::CNT_W-1:0]  r_rem;
    logic                       r_lit;
    logic                       r_ov;
    rld_pkg::t_out              r_out;

    logic w_active;
    logic w_adv;
    logic w_last;

    assign w_active  = (r_rem != '0) || r_lit;
    assign w_adv     = w_active && (!r_ov || i_pop);
    assign w_last    = (r_rem == '0) || ((r_rem == rld_pkg::CNT_W'(1)) && !r_lit);
    // take the next job when idle or as the current one hands out its final byte
    assign o_cmd_pop = i_cmd_valid && (!w_active || (w_adv && w_last));

    assign o_empty = !r_ov;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.out_byte    <= (r_rem != '0) ? r_rep_sym : r_lit_sym;
            r_out.last_of_run <= w_last;
        end
        if (o_cmd_pop) begin
            r_rep_sym <= i_cmd.rep_sym;
            r_lit_sym <= i_cmd.lit_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_lit <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_rem <= i_cmd.rep_cnt;
                r_lit <= i_cmd.has_lit;
            end else if (w_adv) begin
                if (r_rem != '0) begin
                    r_rem <= r_rem - 1'b1;
                end else begin
                    r_lit <= 1'b0;
                end
            end
            if (w_adv) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/decimal_count_run_length_decoder.sv
// an item becomes a job in the queue, which the back end's single repeat counter
// turns into results in the output register, one result per cycle while the
// receiver pops; digit items make no job and only update the pending count
// a symbol item with n pending repeats yields n + 1 results, a flush yields n
// reset (i_rst_n low, synchronous) clears held symbol and count to 0 and empties
// the job queue and output register
`timescale 1ns / 1ps
`include "decimal_count_run_length_decoder_assert.svh"
module decimal_count_run_length_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  rld_pkg::t_in   i_in,
    output logic           empty,
    input  logic           pop,
    output rld_pkg::t_out  o_out
);

    // front end: tracks held symbol and pending count, turns symbols and
    // flushes into expansion jobs
    logic            w_accept;
    logic            w_push;
    rld_pkg::t_cmd   w_fcmd;

    // job queue between front and back
    rld_pkg::t_cmd   w_qcmd;
    rld_pkg::t_qstat w_qstat;
    logic            w_qpop;

    // input stalls only when the job queue is full
    assign full     = w_qstat.full;
    assign w_accept = push && !w_qstat.full;

    rld_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_in     (i_in),
        .o_push   (w_push),
        .o_cmd    (w_fcmd)
    );

    rld_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_fcmd),
        .i_pop   (w_qpop),
        .o_cmd   (w_qcmd),
        .o_stat  (w_qstat)
    );

    // back end: counts out repeats, then the literal, into the output register
    rld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_qcmd),
        .i_cmd_valid (!w_qstat.empty),
        .o_cmd_pop   (w_qpop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

    // a symbol transaction always leaves a job in the queue
    `RLD_ASSERT_NEXT(a_sym_queued, i_clk, i_rst_n,
        w_accept && !i_in.flush && !rld_pkg::is_digit(i_in.in_byte), w_qstat.count != '0)
    // a digit transaction never adds a job
    `RLD_ASSERT_NEXT(a_digit_no_job, i_clk, i_rst_n,
        w_accept && !i_in.flush && rld_pkg::is_digit(i_in.in_byte),
        w_qstat.count <= $past(w_qstat.count))
    // queue flags agree with each other
    `RLD_ASSERT_NOW(a_q_flags, i_clk, i_rst_n, w_qstat.full, !w_qstat.empty)

endmodule

>>> verif/decimal_count_run_length_decoder_test.sv
`timescale 1ns / 1ps
module decimal_count_run_length_decoder_test;

    // clock, reset and block ports
    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          push    = 1'b0;
    logic          full;
    rld_pkg::t_in  i_in    = '0;
    logic          empty;
    logic          pop     = 1'b0;
    rld_pkg::t_out o_out;

    decimal_count_run_length_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_in    (i_in),
        .empty   (empty),
        .pop     (pop),
        .o_out   (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder state as we expect it to be
    logic [rld_pkg::BYTE_W-1:0] held_sym;
    logic [rld_pkg::CNT_W-1:0]  repeat_cnt;

    // decoded bytes still to come out of the block, oldest first
    rld_pkg::t_out decoded_q[$];

    // idle percentages for each side, and a long receiver hold-off
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int hold_left     = 0;

    // run statistics
    int errors        = 0;
    int items_sent    = 0;
    int bytes_checked = 0;
    int full_stalls   = 0;
    int longest_run   = 0;

    // work out the output transactions caused by one accepted input transaction
    task automatic expand_item(input rld_pkg::t_in item);
        rld_pkg::t_out run_q[$];
        rld_pkg::t_out r;
        int            c;
        if (!item.flush && item.in_byte >= rld_pkg::ASCII_ZERO
                && item.in_byte <= rld_pkg::ASCII_NINE) begin
            // digit: grow the count, saturating instead of wrapping
            c = int'(repeat_cnt) * 10 + int'(item.in_byte - rld_pkg::ASCII_ZERO);
            if (c > rld_pkg::MAX_REPEAT)
                c = rld_pkg::MAX_REPEAT;
            repeat_cnt = rld_pkg::CNT_W'(c);
        end else begin
            // symbol or flush: pending repeats of the held symbol go out first
            for (int k = 0; k < int'(repeat_cnt); k++) begin
                r.out_byte    = held_sym;
                r.last_of_run = 1'b0;
                run_q.push_back(r);
            end
            repeat_cnt = '0;
            // a symbol then goes out itself and becomes the held one
            if (!item.flush) begin
                held_sym      = item.in_byte;
                r.out_byte    = item.in_byte;
                r.last_of_run = 1'b0;
                run_q.push_back(r);
            end
        end
        // only the final byte of this item carries the marker
        if (run_q.size() > 0)
            run_q[run_q.size()-1].last_of_run = 1'b1;
        if (run_q.size() > longest_run)
            longest_run = run_q.size();
        foreach (run_q[i])
            decoded_q.push_back(run_q[i]);
    endtask

    // offer one input transaction, idling first at the current rate
    // called and returning just after a falling edge; push is left high
    task automatic send_item(input logic [rld_pkg::BYTE_W-1:0] b, input logic fl);
        rld_pkg::t_in item;
        item.in_byte = b;
        item.flush   = fl;
        while ($urandom_range(1, 100) <= send_idle_pct) begin
            push = 1'b0;
            i_in = 9'($urandom_range(0, 511));
            @(negedge i_clk);
        end
        push = 1'b1;
        i_in = item;
        @(posedge i_clk);
        // keep offering while the block pushes back
        while (full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        expand_item(item);
        items_sent++;
        @(negedge i_clk);
    endtask

    // decimal count after a symbol, optionally with a leading zero
    task automatic send_count(input int n, input bit lead_zero);
        string s;
        s = $sformatf("%0d", n);
        if (lead_zero)
            send_item("0", 1'b0);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // random symbol: half from a DNA alphabet, half any non-digit byte
    function automatic logic [rld_pkg::BYTE_W-1:0] pick_symbol();
        string                      bases;
        logic [rld_pkg::BYTE_W-1:0] b;
        bases = "ACGT";
        if ($urandom_range(0, 1))
            return bases[$urandom_range(0, 3)];
        do
            b = 8'($urandom_range(0, 255));
        while (b >= rld_pkg::ASCII_ZERO && b <= rld_pkg::ASCII_NINE);
        return b;
    endfunction

    // sender pauses until every expected byte has come out
    task automatic wait_for_drain();
        int guard;
        guard = 0;
        push  = 1'b0;
        while (decoded_q.size() != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    // digits before any symbol repeat the reset symbol zero
    task automatic test_digits_before_symbol();
        send_item("5", 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // plain symbol, then a count that repeats it before the next symbol
    task automatic test_symbol_counts();
        send_item("A", 1'b0);
        send_item("3", 1'b0);
        send_item("B", 1'b0);
    endtask

    // count overflow saturates, both from 999 and from 64
    task automatic test_count_saturation();
        send_item("9", 1'b0);
        send_item("9", 1'b0);
        send_item("9", 1'b0);
        send_item("D", 1'b0);
        send_item("6", 1'b0);
        send_item("4", 1'b0);
        send_item("E", 1'b0);
    endtask

    // leading zeros add nothing to the count
    task automatic test_leading_zeros();
        send_item("0", 1'b0);
        send_item("0", 1'b0);
        send_item("7", 1'b0);
        send_item("F", 1'b0);
    endtask

    // flush with a digit byte, flush with nothing pending
    task automatic test_flush_cases();
        send_item("2", 1'b0);
        send_item("5", 1'b1);
        send_item(8'hff, 1'b1);
    endtask

    // byte extremes and the bytes just outside the digit range
    task automatic test_byte_extremes();
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h2f, 1'b0);
        send_item(8'h3a, 1'b0);
        send_item("1", 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // random stream at given idle rates: mostly well-formed symbol/count runs
    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
        int stop_at;
        int r;
        int n;
        wait_for_drain();
        // change rates away from the falling edge the receiver acts on
        @(posedge i_clk);
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        @(negedge i_clk);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                send_item(pick_symbol(), 1'b0);
                if ($urandom_range(0, 99) < 60) begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        n = $urandom_range(1, 9);
                    else if (r < 90)
                        n = $urandom_range(10, rld_pkg::MAX_REPEAT);
                    else
                        n = $urandom_range(rld_pkg::MAX_REPEAT + 1, 999);
                    send_count(n, $urandom_range(0, 9) == 0);
                end
                if ($urandom_range(0, 99) < 8)
                    send_item(8'($urandom_range(0, 255)), 1'b1);
            end else if (r < 90) begin
                // noise: any byte, digits included
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                // stray flush with any byte
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    // receiver holds off for a long stretch while long runs keep being offered
    task automatic test_output_hold();
        wait_for_drain();
        @(posedge i_clk);
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_left     = 400;
        @(negedge i_clk);
        for (int i = 0; i < 10; i++) begin
            send_item(pick_symbol(), 1'b0);
            send_count(rld_pkg::MAX_REPEAT, 1'b0);
        end
        send_item(8'h00, 1'b1);
        wait_for_drain();
    endtask

    // receiver: pop decided at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop = 1'b0;
        end else if (hold_left > 0) begin
            pop = 1'b0;
            hold_left--;
        end else if ($urandom_range(1, 100) <= pop_stall_pct) begin
            pop = 1'b0;
        end else begin
            pop = 1'b1;
        end
    end

    // every accepted output transaction against the oldest expected byte
    always @(posedge i_clk) begin : check_output
        rld_pkg::t_out want;
        if (i_rst_n && pop && !empty) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected output transaction: out_byte=%02h last_of_run=%0b",
                       o_out.out_byte, o_out.last_of_run);
                errors++;
            end else begin
                want = decoded_q.pop_front();
                bytes_checked++;
                if (o_out.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, o_out.out_byte);
                    errors++;
                end
                if (o_out.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last_of_run, o_out.last_of_run);
                    errors++;
                end
            end
        end
    end

    initial begin
        held_sym   = '0;
        repeat_cnt = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed cases from the reset state
        test_digits_before_symbol();
        test_symbol_counts();
        test_count_saturation();
        test_leading_zeros();
        test_flush_cases();
        test_byte_extremes();

        // random stream under each idle pattern
        test_random_phase(0, 0, 100);
        test_random_phase(70, 0, 100);
        test_random_phase(0, 70, 100);
        test_random_phase(6, 6, 100);

        // back-pressure all the way to the input
        test_output_hold();

        repeat (10) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            $error("%0d expected output transactions never arrived", decoded_q.size());
            errors++;
        end
        $display("run covered %0d input and %0d output transactions, longest run %0d bytes",
                 items_sent, bytes_checked, longest_run);
        $display("input held off by full for %0d cycles", full_stalls);
        if (errors == 0) begin
            $display("decimal_count_run_length_decoder: match");
        end else begin
            $display("decimal_count_run_length_decoder: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("decimal_count_run_length_decoder: mismatch");
        $finish;
    end

endmodule
